@@ rtl/core/hsl2rgb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared types and constants for the HSL to RGB conversion unit.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int CHAN_FRAC_BITS = 12;
  localparam int HUE_FRAC_BITS  = 4;

  localparam int CHAN_W = CHAN_FRAC_BITS + 1;
  localparam int HUE_W  = 14;
  // reduced hue always stays below one full circle
  localparam int HUE_RED_W = 13;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [HUE_W-1:0]     hue_t;
  typedef logic [HUE_RED_W-1:0] hue_red_t;
  typedef logic [2:0]           sector_t;

  localparam chan_t CHAN_ONE  = chan_t'(1 << CHAN_FRAC_BITS);
  localparam int    CHAN_HALF = 1 << (CHAN_FRAC_BITS - 1);

  localparam int DEG30    = 30 << HUE_FRAC_BITS;
  localparam int DEG60    = 60 << HUE_FRAC_BITS;
  localparam int DEG120   = 120 << HUE_FRAC_BITS;
  localparam int DEG180   = 180 << HUE_FRAC_BITS;
  localparam int DEG210   = 210 << HUE_FRAC_BITS;
  localparam int DEG240   = 240 << HUE_FRAC_BITS;
  localparam int DEG300   = 300 << HUE_FRAC_BITS;
  localparam int HUE_FULL = 360 << HUE_FRAC_BITS;

  // every sector width is 15 * 2^k hue units, so pos = floor(d * 2^m / 15)
  localparam int RECIP15 = 4369;  // 65535 / 15

  // shift classes for the sector width (30, 60 or 120 degrees)
  localparam logic [1:0] WID_30  = 2'd0;
  localparam logic [1:0] WID_60  = 2'd1;
  localparam logic [1:0] WID_120 = 2'd2;

  // sector codes
  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYN = 3'd2;
  localparam sector_t SEC_CYN_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;
  localparam sector_t SEC_MAG_RED = 3'd5;

  function automatic chan_t sat_one(input logic [CHAN_W:0] v);
    return (v > {1'b0, CHAN_ONE}) ? CHAN_ONE : v[CHAN_W-1:0];
  endfunction

endpackage

@@ rtl/core/hsl_to_rgb_conversion_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_conversion_unit
// Seven-stage pipeline: hue wrap, sector decode and blend, level mixing.
// An item moves through the stage registers 0 to 6 in order; out_valid is
// the valid bit of stage 6.
// Throughput: one item per cycle; each stage holds on back-pressure and
// empty stages fill up, so in_ready only drops when every stage is full.
// Reset clears all stage valid bits and sets hue_mode to 1 (six sectors).
// ----------------------------------------------------------------------------
module hsl_to_rgb_conversion_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsl2rgb_pkg::hue_t         hue,
  input  hsl2rgb_pkg::chan_t        lightness,
  input  hsl2rgb_pkg::chan_t        saturation,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsl2rgb_pkg::chan_t        red,
  output hsl2rgb_pkg::chan_t        green,
  output hsl2rgb_pkg::chan_t        blue
);

  localparam int NSTAGE = 7;
  localparam int CW     = hsl2rgb_pkg::CHAN_W;
  localparam int CF     = hsl2rgb_pkg::CHAN_FRAC_BITS;

  logic              hue_mode;
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] en;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_mode <= 1'b1;
    end else if (cfg_valid) begin
      hue_mode <= cfg_data;
    end
  end

  // per-stage flow control
  always_comb begin
    en[NSTAGE-1] = !v_q[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_q[NSTAGE-1];

  // stage 0: hue wrap, clamp lightness and saturation
  hsl2rgb_pkg::hue_red_t h0;
  hsl2rgb_pkg::chan_t    l0, s0;
  hsl2rgb_pkg::hue_t     h_wrap;

  always_comb begin
    if (hue >= hsl2rgb_pkg::hue_t'(2 * hsl2rgb_pkg::HUE_FULL)) begin
      h_wrap = hue - hsl2rgb_pkg::hue_t'(2 * hsl2rgb_pkg::HUE_FULL);
    end else if (hue >= hsl2rgb_pkg::hue_t'(hsl2rgb_pkg::HUE_FULL)) begin
      h_wrap = hue - hsl2rgb_pkg::hue_t'(hsl2rgb_pkg::HUE_FULL);
    end else begin
      h_wrap = hue;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h0 <= h_wrap[hsl2rgb_pkg::HUE_RED_W-1:0];
      l0 <= hsl2rgb_pkg::sat_one({1'b0, lightness});
      s0 <= hsl2rgb_pkg::sat_one({1'b0, saturation});
    end
  end

  // stage 1: sector decode, scaled offset, l*s product
  hsl2rgb_pkg::sector_t  sec_n, sec1;
  hsl2rgb_pkg::hue_red_t start_n;
  logic [1:0]            wid_n;
  logic [10:0]           d_n;
  logic [15:0]           x_n, x1;
  logic [2*CW-1:0]       prod1;
  hsl2rgb_pkg::chan_t    l1, s1;

  always_comb begin
    sec_n   = hsl2rgb_pkg::SEC_RED_YEL;
    start_n = '0;
    wid_n   = hsl2rgb_pkg::WID_60;
    if (hue_mode) begin
      priority if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG60)) begin
        sec_n   = hsl2rgb_pkg::SEC_RED_YEL;
        start_n = '0;
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG120)) begin
        sec_n   = hsl2rgb_pkg::SEC_YEL_GRN;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG60);
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG180)) begin
        sec_n   = hsl2rgb_pkg::SEC_GRN_CYN;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG120);
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG240)) begin
        sec_n   = hsl2rgb_pkg::SEC_CYN_BLU;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG180);
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG300)) begin
        sec_n   = hsl2rgb_pkg::SEC_BLU_MAG;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG240);
      end else begin
        sec_n   = hsl2rgb_pkg::SEC_MAG_RED;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG300);
      end
    end else begin
      // stretched red-yellow, compressed green-blue
      priority if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG120)) begin
        sec_n   = hsl2rgb_pkg::SEC_RED_YEL;
        start_n = '0;
        wid_n   = hsl2rgb_pkg::WID_120;
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG180)) begin
        sec_n   = hsl2rgb_pkg::SEC_YEL_GRN;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG120);
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG210)) begin
        sec_n   = hsl2rgb_pkg::SEC_GRN_CYN;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG180);
        wid_n   = hsl2rgb_pkg::WID_30;
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG240)) begin
        sec_n   = hsl2rgb_pkg::SEC_CYN_BLU;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG210);
        wid_n   = hsl2rgb_pkg::WID_30;
      end else if (h0 < hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG300)) begin
        sec_n   = hsl2rgb_pkg::SEC_BLU_MAG;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG240);
      end else begin
        sec_n   = hsl2rgb_pkg::SEC_MAG_RED;
        start_n = hsl2rgb_pkg::hue_red_t'(hsl2rgb_pkg::DEG300);
      end
    end
    d_n = 11'(h0 - start_n);
    // offset scaled so that a divide by 15 gives the 12-bit position
    unique case (wid_n)
      hsl2rgb_pkg::WID_30:  x_n = 16'({d_n, 7'b0});
      hsl2rgb_pkg::WID_120: x_n = 16'({d_n, 5'b0});
      default:              x_n = 16'({d_n, 6'b0});
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec1  <= sec_n;
      x1    <= x_n;
      prod1 <= {{CW{1'b0}}, l0} * {{CW{1'b0}}, s0};
      l1    <= l0;
      s1    <= s0;
    end
  end

  // stage 2: reciprocal multiply, round l*s
  logic [28:0]          qm_n;
  logic [CF-1:0]        q2;
  logic [15:0]          x2;
  hsl2rgb_pkg::chan_t   ls2, l2, s2;
  hsl2rgb_pkg::sector_t sec2;
  logic [2*CW-1:0]      lsr_n;

  assign qm_n  = {13'b0, x1} * 29'(hsl2rgb_pkg::RECIP15);
  assign lsr_n = prod1 + (2*CW)'(hsl2rgb_pkg::CHAN_HALF);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q2   <= qm_n[16+CF-1:16];
      x2   <= x1;
      ls2  <= lsr_n[CF+CW-1:CF];
      l2   <= l1;
      s2   <= s1;
      sec2 <= sec1;
    end
  end

  // stage 3: quotient correction, top level
  logic [15:0]          q15_n, rem_n;
  logic [CF-1:0]        pos_n, pos3;
  logic [CW:0]          top_raw_n;
  hsl2rgb_pkg::chan_t   top3, l3;
  logic                 szero3;
  hsl2rgb_pkg::sector_t sec3;

  always_comb begin
    q15_n = {q2, 4'b0} - {4'b0, q2};
    rem_n = x2 - q15_n;
    pos_n = (rem_n >= 16'd15) ? q2 + 1'b1 : q2;
    if ({l2, 1'b0} <= {1'b0, hsl2rgb_pkg::CHAN_ONE}) begin
      top_raw_n = {1'b0, l2} + {1'b0, ls2};
    end else begin
      top_raw_n = {1'b0, l2} + {1'b0, s2} - {1'b0, ls2};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pos3   <= pos_n;
      top3   <= hsl2rgb_pkg::sat_one(top_raw_n);
      l3     <= l2;
      szero3 <= (s2 == '0);
      sec3   <= sec2;
    end
  end

  // stage 4: bottom level and span
  logic [CW:0]          l2x_n;
  hsl2rgb_pkg::chan_t   bot_n, bot4, span4, top4, l4;
  logic [CF-1:0]        pos4;
  logic                 szero4;
  hsl2rgb_pkg::sector_t sec4;

  always_comb begin
    l2x_n = {l3, 1'b0};
    if (l2x_n >= {1'b0, top3}) begin
      bot_n = hsl2rgb_pkg::sat_one(l2x_n - {1'b0, top3});
    end else begin
      bot_n = '0;
    end
    if (bot_n > top3) begin
      bot_n = top3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      bot4   <= bot_n;
      span4  <= top3 - bot_n;
      top4   <= top3;
      l4     <= l3;
      pos4   <= pos3;
      szero4 <= szero3;
      sec4   <= sec3;
    end
  end

  // stage 5: blend products
  logic [2*CW-1:0]      pup5, pdn5;
  hsl2rgb_pkg::chan_t   bot5, top5, l5;
  logic                 szero5;
  hsl2rgb_pkg::sector_t sec5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pup5   <= {{CW{1'b0}}, 1'b0, pos4} * {{CW{1'b0}}, span4};
      pdn5   <= {{CW{1'b0}}, hsl2rgb_pkg::CHAN_ONE - {1'b0, pos4}} * {{CW{1'b0}}, span4};
      bot5   <= bot4;
      top5   <= top4;
      l5     <= l4;
      szero5 <= szero4;
      sec5   <= sec4;
    end
  end

  // stage 6: round, route to channels
  logic [2*CW-1:0] upr_n, dnr_n;
  logic [CW:0]     up_n, dn_n, top_w, bot_w, r_n, g_n, b_n;

  always_comb begin
    upr_n = pup5 + (2*CW)'(hsl2rgb_pkg::CHAN_HALF);
    dnr_n = pdn5 + (2*CW)'(hsl2rgb_pkg::CHAN_HALF);
    up_n  = {1'b0, bot5} + {1'b0, upr_n[CF+CW-1:CF]};
    dn_n  = {1'b0, bot5} + {1'b0, dnr_n[CF+CW-1:CF]};
    top_w = {1'b0, top5};
    bot_w = {1'b0, bot5};
    if (szero5) begin
      r_n = {1'b0, l5};
      g_n = {1'b0, l5};
      b_n = {1'b0, l5};
    end else begin
      unique case (sec5)
        hsl2rgb_pkg::SEC_RED_YEL: begin
          r_n = top_w; g_n = up_n;  b_n = bot_w;
        end
        hsl2rgb_pkg::SEC_YEL_GRN: begin
          r_n = dn_n;  g_n = top_w; b_n = bot_w;
        end
        hsl2rgb_pkg::SEC_GRN_CYN: begin
          r_n = bot_w; g_n = top_w; b_n = up_n;
        end
        hsl2rgb_pkg::SEC_CYN_BLU: begin
          r_n = bot_w; g_n = dn_n;  b_n = top_w;
        end
        hsl2rgb_pkg::SEC_BLU_MAG: begin
          r_n = up_n;  g_n = bot_w; b_n = top_w;
        end
        default: begin
          r_n = top_w; g_n = bot_w; b_n = dn_n;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      red   <= hsl2rgb_pkg::sat_one(r_n);
      green <= hsl2rgb_pkg::sat_one(g_n);
      blue  <= hsl2rgb_pkg::sat_one(b_n);
    end
  end

  // checks
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red <= hsl2rgb_pkg::CHAN_ONE) && (green <= hsl2rgb_pkg::CHAN_ONE) &&
                  (blue <= hsl2rgb_pkg::CHAN_ONE))
    else $error("output channel above one");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !v_q[NSTAGE-1] |-> in_ready)
    else $error("input stalled with empty output stage");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> hue_mode == $past(cfg_data))
    else $error("hue_mode not updated by config transfer");

endmodule
